>>> sv/isf_pkg.sv
package isf_pkg;

    // Fixed widths of the series and of the arithmetic
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 13;
    localparam int POS_LIMIT  = 4096;
    localparam int MAX_IVL    = 64;
    localparam int FRAC_BITS  = 16;
    localparam int FEAT_W     = 48;
    localparam int PROD_W     = 64;
    localparam int DEN_W      = 40;
    localparam int DIVD_W     = PROD_W + FRAC_BITS;
    localparam int UCNT_W     = $clog2(DIVD_W + 1);

    // Configuration register indexes
    localparam logic [1:0] REG_WSTART = 2'd0;
    localparam logic [1:0] REG_LEN    = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    // Feature codes
    localparam logic [2:0] K_SLOPE  = 3'd0;
    localparam logic [2:0] K_MEAN   = 3'd1;
    localparam logic [2:0] K_VAR    = 3'd2;
    localparam logic [2:0] K_WMEAN  = 3'd3;
    localparam logic [2:0] K_WVAR   = 3'd4;
    localparam logic [2:0] K_START  = 3'd5;
    localparam logic [2:0] K_END    = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       series_begin;
    } t_sample;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_value;
        logic [2:0]               feature_kind;
        logic [5:0]               interval_number;
        logic                     last_of_run;
    } t_feature;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } t_uop;

    // Request to the shared arithmetic unit
    typedef struct packed {
        logic              start;
        t_uop              op;
        logic              neg;
        logic [PROD_W-1:0] a;
        logic [DEN_W-1:0]  b;
    } t_unit_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] result;
    } t_unit_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_EMIT
    } t_state;

    // Sequencer steps for a completed interval and, after the last one, for the window
    typedef enum logic [4:0] {
        SP_SL_P,
        SP_SL_NN,
        SP_SL_DEN,
        SP_SL_DIV,
        SP_MN_DIV,
        SP_VR_NQ,
        SP_VR_SS,
        SP_VR_DEN,
        SP_VR_DIV,
        SP_WN,
        SP_WM_DIV,
        SP_WV_NQ,
        SP_WV_SS,
        SP_WV_DEN,
        SP_WV_DIV,
        SP_START,
        SP_END
    } t_step;

endpackage

>>> sv/isf_unit.sv
module isf_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isf_pkg::t_unit_req  i_req,
    output isf_pkg::t_unit_rsp  o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    isf_pkg::t_uop                    r_op;
    logic                             r_neg;
    logic [isf_pkg::PROD_W-1:0]       r_a;
    logic [isf_pkg::DEN_W-1:0]        r_b;
    logic [isf_pkg::DIVD_W-1:0]       r_acc;
    logic [isf_pkg::DEN_W-1:0]        r_rem;
    logic [isf_pkg::UCNT_W-1:0]       r_cnt;

    logic [isf_pkg::DEN_W+1:0]        w_trial;
    logic                             w_geq;
    logic                             w_sat;
    logic [isf_pkg::FEAT_W-1:0]       w_mag;
    logic [isf_pkg::FEAT_W-1:0]       w_field;

    // Restoring divide step: one quotient bit per cycle
    assign w_trial = {1'b0, r_rem, r_acc[isf_pkg::DIVD_W-1]} - {2'b00, r_b};
    assign w_geq   = !w_trial[isf_pkg::DEN_W+1];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= isf_pkg::UCNT_W'(isf_pkg::DIVD_W);
            end else if (r_busy) begin
                if (r_op == isf_pkg::UOP_MUL) begin
                    if (r_b == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == isf_pkg::UCNT_W'(1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Datapath: shift-add multiply or shift-subtract divide
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_neg <= i_req.neg;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_rem <= '0;
            if (i_req.op == isf_pkg::UOP_MUL) begin
                r_acc <= '0;
            end else begin
                r_acc <= {i_req.a, isf_pkg::FRAC_BITS'(0)}
                         + isf_pkg::DIVD_W'(i_req.b >> 1);
            end
        end else if (r_busy) begin
            if (r_op == isf_pkg::UOP_MUL) begin
                if (r_b != '0) begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + isf_pkg::DIVD_W'(r_a);
                    end
                    r_a <= {r_a[isf_pkg::PROD_W-2:0], 1'b0};
                    r_b <= r_b >> 1;
                end
            end else begin
                r_rem <= w_geq ? w_trial[isf_pkg::DEN_W-1:0]
                               : {r_rem[isf_pkg::DEN_W-2:0], r_acc[isf_pkg::DIVD_W-1]};
                r_acc <= {r_acc[isf_pkg::DIVD_W-2:0], w_geq};
            end
        end
    end

    // Saturate quotient to 2^47 and apply the sign
    assign w_sat = (|r_acc[isf_pkg::DIVD_W-1:isf_pkg::FEAT_W])
                   || (r_acc[isf_pkg::FEAT_W-1] && (|r_acc[isf_pkg::FEAT_W-2:0]));
    assign w_mag = w_sat ? {1'b1, {(isf_pkg::FEAT_W-1){1'b0}}}
                         : r_acc[isf_pkg::FEAT_W-1:0];

    always_comb begin
        if (r_neg) begin
            w_field = -w_mag;
        end else if (w_mag[isf_pkg::FEAT_W-1]) begin
            w_field = {1'b0, {(isf_pkg::FEAT_W-1){1'b1}}};
        end else begin
            w_field = w_mag;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == isf_pkg::UOP_MUL) ? r_acc[isf_pkg::PROD_W-1:0]
                                                      : isf_pkg::PROD_W'(w_field);

endmodule

>>> sv/interval_slope_mean_variance.sv
// Channel   | Direction | Signals                                   | Payload
// sample    | in        | i_sample_valid / o_sample_ready           | t_sample
// feature   | out       | o_feature_valid / i_feature_ready         | t_feature
// config    | in        | psel penable pwrite paddr pwdata / prdata | 3 registers
//
// A sample that does not end an interval is taken while the block is idle.
// A sample that ends an interval runs a sequence on the shared multiply/divide
// unit: a multiply is shift-add and a divide is restoring shift-subtract.
// No sample is taken until the last result of the run has been transferred;
// a stalled result holds the sequencer. Synchronous active-low reset.
module interval_slope_mean_variance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_sample_valid,
    output logic               o_sample_ready,
    input  isf_pkg::t_sample   i_sample,
    output logic               o_feature_valid,
    input  logic               i_feature_ready,
    output isf_pkg::t_feature  o_feature,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration
    logic [11:0] r_wstart;
    logic [12:0] r_len;
    logic [6:0]  r_count;
    logic [12:0] w_len;
    logic [6:0]  w_count;

    // Series state
    logic [12:0]        r_pos;
    logic [6:0]         r_idx;
    logic [12:0]        r_cin;
    logic signed [28:0] r_is;
    logic [44:0]        r_iq;
    logic signed [40:0] r_iw;
    logic signed [28:0] r_wsum;
    logic [44:0]        r_wsq;

    // Run work registers
    isf_pkg::t_state    r_state, n_state;
    isf_pkg::t_step     r_step;
    logic [12:0]        r_n;
    logic [5:0]         r_inum;
    logic               r_final;
    logic [63:0]        r_t;
    logic signed [63:0] r_num;
    logic [39:0]        r_den;
    logic [19:0]        r_nw;
    isf_pkg::t_feature  r_out;
    logic               r_out_valid;

    isf_pkg::t_unit_req w_req;
    isf_pkg::t_unit_rsp w_rsp;

    logic               w_acc;
    logic               w_begin;
    logic signed [15:0] w_x;
    logic [12:0]        e_pos, e_cin;
    logic [6:0]         e_idx;
    logic signed [28:0] e_is, e_wsum;
    logic [44:0]        e_iq, e_wsq;
    logic signed [40:0] e_iw;
    logic signed [31:0] w_xx;
    logic signed [29:0] w_cx;
    logic               w_take;
    logic [12:0]        w_cin_n;
    logic               w_trig;
    logic [28:0]        w_s_abs, w_ws_abs;
    logic               w_is_div, w_is_direct, w_last;
    logic signed [63:0] w_ps, w_w64, w_slope_num;
    logic [63:0]        w_prod;
    logic [63:0]        w_var_num;
    logic [47:0]        w_start_val, w_end_val;
    logic               w_out_done;

    assign pready = 1'b1;

    // Effective interval length and count
    assign w_len   = (r_len < 13'd2) ? 13'd2 : r_len;
    assign w_count = (r_count == 7'd0) ? 7'd1
                   : (r_count > 7'(isf_pkg::MAX_IVL)) ? 7'(isf_pkg::MAX_IVL) : r_count;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart <= '0;
            r_len    <= 13'd2;
            r_count  <= 7'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                isf_pkg::REG_WSTART: r_wstart <= pwdata[11:0];
                isf_pkg::REG_LEN:    r_len    <= pwdata[12:0];
                isf_pkg::REG_COUNT:  r_count  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            isf_pkg::REG_WSTART: prdata = 32'(r_wstart);
            isf_pkg::REG_LEN:    prdata = 32'(r_len);
            isf_pkg::REG_COUNT:  prdata = 32'(r_count);
            default:             prdata = '0;
        endcase
    end

    // Sample transfer: clear on series begin, then accumulate
    assign w_acc   = i_sample_valid && o_sample_ready;
    assign w_begin = i_sample.series_begin;
    assign w_x     = i_sample.sample_value;
    assign e_pos   = w_begin ? '0 : r_pos;
    assign e_cin   = w_begin ? '0 : r_cin;
    assign e_idx   = w_begin ? '0 : r_idx;
    assign e_is    = w_begin ? '0 : r_is;
    assign e_iq    = w_begin ? '0 : r_iq;
    assign e_iw    = w_begin ? '0 : r_iw;
    assign e_wsum  = w_begin ? '0 : r_wsum;
    assign e_wsq   = w_begin ? '0 : r_wsq;
    assign w_xx    = w_x * w_x;
    assign w_cx    = $signed({1'b0, e_cin}) * w_x;
    assign w_take  = (e_pos < 13'(isf_pkg::POS_LIMIT)) && (e_pos >= {1'b0, r_wstart})
                     && (e_idx < w_count);
    assign w_cin_n = e_cin + 13'd1;
    assign w_trig  = w_take && (w_cin_n >= w_len);

    // Step classes
    assign w_is_div = (r_step == isf_pkg::SP_SL_DIV) || (r_step == isf_pkg::SP_MN_DIV)
                   || (r_step == isf_pkg::SP_VR_DIV) || (r_step == isf_pkg::SP_WM_DIV)
                   || (r_step == isf_pkg::SP_WV_DIV);
    assign w_is_direct = (r_step == isf_pkg::SP_START) || (r_step == isf_pkg::SP_END);
    assign w_last = ((r_step == isf_pkg::SP_VR_DIV) && !r_final)
                 || (r_step == isf_pkg::SP_END);
    assign w_out_done = r_out_valid && i_feature_ready;

    function automatic isf_pkg::t_step f_next(input isf_pkg::t_step s, input logic fin);
        isf_pkg::t_step nx;
        unique case (s)
            isf_pkg::SP_SL_P:   nx = isf_pkg::SP_SL_NN;
            isf_pkg::SP_SL_NN:  nx = isf_pkg::SP_SL_DEN;
            isf_pkg::SP_SL_DEN: nx = isf_pkg::SP_SL_DIV;
            isf_pkg::SP_SL_DIV: nx = isf_pkg::SP_MN_DIV;
            isf_pkg::SP_MN_DIV: nx = isf_pkg::SP_VR_NQ;
            isf_pkg::SP_VR_NQ:  nx = isf_pkg::SP_VR_SS;
            isf_pkg::SP_VR_SS:  nx = isf_pkg::SP_VR_DEN;
            isf_pkg::SP_VR_DEN: nx = isf_pkg::SP_VR_DIV;
            isf_pkg::SP_VR_DIV: nx = fin ? isf_pkg::SP_WN : isf_pkg::SP_SL_P;
            isf_pkg::SP_WN:     nx = isf_pkg::SP_WM_DIV;
            isf_pkg::SP_WM_DIV: nx = isf_pkg::SP_WV_NQ;
            isf_pkg::SP_WV_NQ:  nx = isf_pkg::SP_WV_SS;
            isf_pkg::SP_WV_SS:  nx = isf_pkg::SP_WV_DEN;
            isf_pkg::SP_WV_DEN: nx = isf_pkg::SP_WV_DIV;
            isf_pkg::SP_WV_DIV: nx = isf_pkg::SP_START;
            isf_pkg::SP_START:  nx = isf_pkg::SP_END;
            default:            nx = isf_pkg::SP_SL_P;
        endcase
        return nx;
    endfunction

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isf_pkg::ST_IDLE: if (w_acc && w_trig) n_state = isf_pkg::ST_LOAD;
            isf_pkg::ST_LOAD: n_state = w_is_direct ? isf_pkg::ST_EMIT : isf_pkg::ST_RUN;
            isf_pkg::ST_RUN: begin
                if (w_rsp.done) n_state = w_is_div ? isf_pkg::ST_EMIT : isf_pkg::ST_LOAD;
            end
            isf_pkg::ST_EMIT: begin
                if (w_out_done) n_state = w_last ? isf_pkg::ST_IDLE : isf_pkg::ST_LOAD;
            end
            default: n_state = isf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= isf_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Magnitudes of the sums
    assign w_s_abs  = r_is[28]   ? 29'(-r_is)   : 29'(r_is);
    assign w_ws_abs = r_wsum[28] ? 29'(-r_wsum) : 29'(r_wsum);

    // Outputs of the sequencer: ready and the unit request
    always_comb begin
        o_sample_ready = (r_state == isf_pkg::ST_IDLE);
        w_req.start    = (r_state == isf_pkg::ST_LOAD) && !w_is_direct;
        w_req.op       = w_is_div ? isf_pkg::UOP_DIV : isf_pkg::UOP_MUL;
        w_req.neg      = 1'b0;
        w_req.a        = '0;
        w_req.b        = '0;
        case (r_step)
            isf_pkg::SP_SL_P: begin
                w_req.a = 64'(w_s_abs);
                w_req.b = 40'(r_n - 13'd1);
            end
            isf_pkg::SP_SL_NN: begin
                w_req.a = 64'(r_n);
                w_req.b = 40'(r_n);
            end
            isf_pkg::SP_SL_DEN: begin
                w_req.a = r_t - 64'd1;
                w_req.b = 40'(r_n);
            end
            isf_pkg::SP_SL_DIV: begin
                w_req.neg = r_num[63];
                w_req.a   = r_num[63] ? 64'(-r_num) : 64'(r_num);
                w_req.b   = r_den;
            end
            isf_pkg::SP_MN_DIV: begin
                w_req.neg = r_is[28];
                w_req.a   = 64'(w_s_abs);
                w_req.b   = 40'(r_n);
            end
            isf_pkg::SP_VR_NQ: begin
                w_req.a = 64'(r_iq);
                w_req.b = 40'(r_n);
            end
            isf_pkg::SP_VR_SS: begin
                w_req.a = 64'(w_s_abs);
                w_req.b = 40'(w_s_abs);
            end
            isf_pkg::SP_VR_DEN: begin
                w_req.a = 64'(r_n);
                w_req.b = 40'(r_n - 13'd1);
            end
            isf_pkg::SP_VR_DIV, isf_pkg::SP_WV_DIV: begin
                w_req.a = 64'(r_num);
                w_req.b = r_den;
            end
            isf_pkg::SP_WN: begin
                w_req.a = 64'(w_count);
                w_req.b = 40'(w_len);
            end
            isf_pkg::SP_WM_DIV: begin
                w_req.neg = r_wsum[28];
                w_req.a   = 64'(w_ws_abs);
                w_req.b   = 40'(r_nw);
            end
            isf_pkg::SP_WV_NQ: begin
                w_req.a = 64'(r_wsq);
                w_req.b = 40'(r_nw);
            end
            isf_pkg::SP_WV_SS: begin
                w_req.a = 64'(w_ws_abs);
                w_req.b = 40'(w_ws_abs);
            end
            isf_pkg::SP_WV_DEN: begin
                w_req.a = 64'(r_nw);
                w_req.b = 40'(r_nw - 20'd1);
            end
            default: ;
        endcase
    end

    isf_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Numerators formed from unit products
    assign w_prod      = w_rsp.result;
    assign w_ps        = r_is[28] ? -$signed(w_prod) : $signed(w_prod);
    assign w_w64       = 64'(r_iw);
    assign w_slope_num = (w_w64 <<< 3) + (w_w64 <<< 2) - (w_ps <<< 2) - (w_ps <<< 1);
    assign w_var_num   = (r_t >= w_prod) ? (r_t - w_prod) : 64'd0;
    assign w_start_val = {19'd0, 13'({1'b0, r_wstart} + 13'd1), 16'd0};
    assign w_end_val   = {11'd0, 21'(r_wstart) + 21'(r_nw), 16'd0};

    // Series state and run data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_idx       <= '0;
            r_cin       <= '0;
            r_is        <= '0;
            r_iq        <= '0;
            r_iw        <= '0;
            r_wsum      <= '0;
            r_wsq       <= '0;
            r_out_valid <= 1'b0;
            r_step      <= isf_pkg::SP_SL_P;
        end else begin
            unique case (r_state)
                isf_pkg::ST_IDLE: begin
                    if (w_acc) begin
                        r_pos  <= e_pos;
                        r_idx  <= e_idx;
                        r_cin  <= e_cin;
                        r_is   <= e_is;
                        r_iq   <= e_iq;
                        r_iw   <= e_iw;
                        r_wsum <= e_wsum;
                        r_wsq  <= e_wsq;
                        if (e_pos < 13'(isf_pkg::POS_LIMIT)) r_pos <= e_pos + 13'd1;
                        if (w_take) begin
                            r_is   <= e_is + 29'(w_x);
                            r_iq   <= e_iq + 45'($unsigned(w_xx));
                            r_iw   <= e_iw + 41'(w_cx);
                            r_wsum <= e_wsum + 29'(w_x);
                            r_wsq  <= e_wsq + 45'($unsigned(w_xx));
                            r_cin  <= w_cin_n;
                        end
                        if (w_trig) begin
                            r_cin   <= '0;
                            r_idx   <= e_idx + 7'd1;
                            r_n     <= w_cin_n;
                            r_inum  <= e_idx[5:0];
                            r_final <= (e_idx + 7'd1) >= w_count;
                            r_step  <= isf_pkg::SP_SL_P;
                        end
                    end
                end
                isf_pkg::ST_LOAD: begin
                    if (w_is_direct) begin
                        r_out_valid           <= 1'b1;
                        r_out.feature_kind    <= (r_step == isf_pkg::SP_START)
                                                 ? isf_pkg::K_START : isf_pkg::K_END;
                        r_out.feature_value   <= (r_step == isf_pkg::SP_START)
                                                 ? w_start_val : w_end_val;
                        r_out.interval_number <= '0;
                        r_out.last_of_run     <= w_last;
                    end
                end
                isf_pkg::ST_RUN: begin
                    if (w_rsp.done) begin
                        if (w_is_div) begin
                            r_out_valid           <= 1'b1;
                            r_out.feature_value   <= w_prod[47:0];
                            r_out.last_of_run     <= w_last;
                            r_out.interval_number <= r_inum;
                            case (r_step)
                                isf_pkg::SP_SL_DIV: r_out.feature_kind <= isf_pkg::K_SLOPE;
                                isf_pkg::SP_MN_DIV: r_out.feature_kind <= isf_pkg::K_MEAN;
                                isf_pkg::SP_VR_DIV: r_out.feature_kind <= isf_pkg::K_VAR;
                                isf_pkg::SP_WM_DIV: begin
                                    r_out.feature_kind    <= isf_pkg::K_WMEAN;
                                    r_out.interval_number <= '0;
                                end
                                default: begin
                                    r_out.feature_kind    <= isf_pkg::K_WVAR;
                                    r_out.interval_number <= '0;
                                end
                            endcase
                        end else begin
                            r_step <= f_next(r_step, r_final);
                            case (r_step)
                                isf_pkg::SP_SL_P:   r_num <= w_slope_num;
                                isf_pkg::SP_VR_SS,
                                isf_pkg::SP_WV_SS:  r_num <= $signed(w_var_num);
                                isf_pkg::SP_SL_DEN,
                                isf_pkg::SP_VR_DEN,
                                isf_pkg::SP_WV_DEN: r_den <= w_prod[39:0];
                                isf_pkg::SP_WN:     r_nw  <= w_prod[19:0];
                                default:            r_t   <= w_prod;
                            endcase
                        end
                    end
                end
                isf_pkg::ST_EMIT: begin
                    if (w_out_done) begin
                        r_out_valid <= 1'b0;
                        r_step      <= f_next(r_step, r_final);
                        if (w_last) begin
                            r_is <= '0;
                            r_iq <= '0;
                            r_iw <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_feature_valid = r_out_valid;
    assign o_feature       = r_out;

endmodule

>>> sv/isf_check.sv
module isf_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_sample_valid,
    input logic               o_sample_ready,
    input isf_pkg::t_sample   i_sample,
    input logic               o_feature_valid,
    input logic               i_feature_ready,
    input isf_pkg::t_feature  o_feature,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [3:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_feature_valid && !i_feature_ready |=> o_feature_valid && $stable(o_feature))
        else $error("feature changed while stalled");

    // No sample transfer while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_feature_valid |-> !o_sample_ready)
        else $error("sample ready with result pending");

    // Window features carry interval number zero
    a_win_inum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_feature_valid && (o_feature.feature_kind >= isf_pkg::K_WMEAN)
        |-> o_feature.interval_number == 6'd0)
        else $error("window feature with interval number");

    // Reset leaves no result pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_feature_valid)
        else $error("result valid after reset");

endmodule

bind interval_slope_mean_variance isf_check u_isf_check (.*);
